@@ hdl/assert_macros.svh @@
// assertion macros shared by the frame decoder modules
// no dependencies; included by files that carry concurrent checks
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge outside reset
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/wsfd_pkg.sv @@
// types and constants for the websocket frame decoder
// no dependencies; imported by every decoder module
package wsfd_pkg;

  // parser phase
  typedef enum logic [2:0] {
    PH_FIRST = 3'd0,
    PH_LEN7  = 3'd1,
    PH_EXT   = 3'd2,
    PH_KEY   = 3'd3,
    PH_DATA  = 3'd4
  } phase_t;

  // result kind codes
  localparam logic KIND_HEADER = 1'b0;
  localparam logic KIND_DATA   = 1'b1;

  // 7-bit length escape codes
  localparam logic [6:0] LEN_EXT16 = 7'd126;

  // extended length and key byte counts, minus one
  localparam logic [2:0] EXT16_COUNT = 3'd1;
  localparam logic [2:0] EXT64_COUNT = 3'd7;
  localparam logic [2:0] KEY_COUNT   = 3'd3;

  localparam int TDATA_W = 80;

  // one result item
  typedef struct packed {
    logic        kind;
    logic [7:0]  data_byte;
    logic        final_flag;
    logic [3:0]  frame_opcode;
    logic        masked_flag;
    logic [63:0] payload_length;
    logic        frame_end;
  } result_t;

endpackage

@@ hdl/websocket_frame_decoder.sv @@
// websocket frame decoder: one stream byte per cycle in, header and payload requests out
// output: each result is registered in the output stage before it appears on m_axis
// throughput: one byte per cycle; a two-entry output stage keeps s_axis_tready high while
// one result waits, so the rate is set only by the downstream ready
// reset: synchronous rst returns the parser to the first header byte and empties the output
// depends on wsfd_pkg, wsfd_parser and wsfd_skid
module websocket_frame_decoder
  import wsfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  logic [7:0]         s_axis_tdata,  // stream_byte
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  // data_byte[7:0], final_flag[8], frame_opcode[12:9], masked_flag[13],
  // payload_length[77:14], zero[79:78]
  output logic [TDATA_W-1:0] m_axis_tdata,
  output logic [0:0]         m_axis_tuser,  // kind
  output logic               m_axis_tlast   // frame_end
);

  logic    accept;
  logic    res_valid;
  result_t res;
  result_t out_res;

  assign accept = s_axis_tvalid && s_axis_tready;

  wsfd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_byte   (s_axis_tdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsfd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept && res_valid),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  // result packing
  assign m_axis_tdata = {2'b00, out_res.payload_length, out_res.masked_flag,
                         out_res.frame_opcode, out_res.final_flag, out_res.data_byte};
  assign m_axis_tuser = out_res.kind;
  assign m_axis_tlast = out_res.frame_end;

endmodule

@@ hdl/wsfd_parser.sv @@
// frame parser: header state, length and key capture, payload unmasking
// depends on wsfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module wsfd_parser
  import wsfd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] in_byte,
  output logic       res_valid,
  output result_t    res
);

  phase_t      phase, phase_next;
  logic        fin_bit, fin_bit_next;
  logic [3:0]  op_nibble, op_nibble_next;
  logic        mask_flag, mask_flag_next;
  logic [2:0]  byte_counter, byte_counter_next;
  logic [63:0] length_value, length_value_next;
  logic [31:0] key_word, key_word_next;
  logic [63:0] remaining_bytes, remaining_bytes_next;
  logic [1:0]  key_index, key_index_next;

  logic        len_done;
  logic        hdr_done;
  logic        data_last;
  logic [7:0]  key_byte;

  // key byte for the current payload position, first key byte in the top bits
  always_comb begin
    case (key_index)
      2'd0:    key_byte = key_word[31:24];
      2'd1:    key_byte = key_word[23:16];
      2'd2:    key_byte = key_word[15:8];
      default: key_byte = key_word[7:0];
    endcase
  end

  // next state and result for the byte at the input
  always_comb begin
    phase_next           = phase;
    fin_bit_next         = fin_bit;
    op_nibble_next       = op_nibble;
    mask_flag_next       = mask_flag;
    byte_counter_next    = byte_counter;
    length_value_next    = length_value;
    key_word_next        = key_word;
    remaining_bytes_next = remaining_bytes;
    key_index_next       = key_index;
    len_done             = 1'b0;
    hdr_done             = 1'b0;
    data_last            = 1'b0;
    res_valid            = 1'b0;
    res                  = '0;

    case (phase)
      PH_LEN7: begin
        mask_flag_next = in_byte[7];
        if (in_byte[6:0] < LEN_EXT16) begin
          length_value_next = {57'd0, in_byte[6:0]};
          len_done          = 1'b1;
        end else begin
          length_value_next = '0;
          phase_next        = PH_EXT;
          byte_counter_next = (in_byte[6:0] == LEN_EXT16) ? EXT16_COUNT : EXT64_COUNT;
        end
      end
      PH_EXT: begin
        length_value_next = {length_value[55:0], in_byte};
        if (byte_counter != 3'd0) begin
          byte_counter_next = byte_counter - 3'd1;
        end else begin
          len_done = 1'b1;
        end
      end
      PH_KEY: begin
        key_word_next = {key_word[23:0], in_byte};
        if (byte_counter != 3'd0) begin
          byte_counter_next = byte_counter - 3'd1;
        end else begin
          hdr_done = 1'b1;
        end
      end
      PH_DATA: begin
        key_index_next       = key_index + 2'd1;
        remaining_bytes_next = remaining_bytes - 64'd1;
        data_last            = (remaining_bytes_next == 64'd0);
        res_valid            = 1'b1;
        res.kind             = KIND_DATA;
        res.data_byte        = mask_flag ? (in_byte ^ key_byte) : in_byte;
        res.frame_end        = data_last;
        if (data_last) begin
          phase_next = PH_FIRST;
        end
      end
      default: begin
        fin_bit_next   = in_byte[7];
        op_nibble_next = in_byte[3:0];
        phase_next     = PH_LEN7;
      end
    endcase

    // length known: collect a key or finish the header
    if (len_done) begin
      if (mask_flag_next) begin
        phase_next        = PH_KEY;
        byte_counter_next = KEY_COUNT;
        key_word_next     = '0;
      end else begin
        hdr_done = 1'b1;
      end
    end

    // header report
    if (hdr_done) begin
      res_valid            = 1'b1;
      res.kind             = KIND_HEADER;
      res.data_byte        = 8'd0;
      res.frame_end        = (length_value_next == 64'd0);
      remaining_bytes_next = length_value_next;
      key_index_next       = 2'd0;
      phase_next           = (length_value_next == 64'd0) ? PH_FIRST : PH_DATA;
    end

    res.final_flag     = fin_bit_next;
    res.frame_opcode   = op_nibble_next;
    res.masked_flag    = mask_flag_next;
    res.payload_length = length_value_next;
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_FIRST;
      fin_bit         <= 1'b0;
      op_nibble       <= 4'd0;
      mask_flag       <= 1'b0;
      byte_counter    <= 3'd0;
      length_value    <= 64'd0;
      key_word        <= 32'd0;
      remaining_bytes <= 64'd0;
      key_index       <= 2'd0;
    end else if (accept) begin
      phase           <= phase_next;
      fin_bit         <= fin_bit_next;
      op_nibble       <= op_nibble_next;
      mask_flag       <= mask_flag_next;
      byte_counter    <= byte_counter_next;
      length_value    <= length_value_next;
      key_word        <= key_word_next;
      remaining_bytes <= remaining_bytes_next;
      key_index       <= key_index_next;
    end
  end

  // checks
  `ASSERT_AT(a_data_remaining, clk, rst, (phase != PH_DATA) || (remaining_bytes != 64'd0),
    "payload phase with no bytes due")
  `ASSERT_AT(a_key_count, clk, rst, (phase != PH_KEY) || (mask_flag && byte_counter <= KEY_COUNT),
    "key phase without mask or with bad count")
  `ASSERT_NEXT(a_frame_wrap, clk, rst, accept && res_valid && res.frame_end, phase == PH_FIRST,
    "frame end did not return to first header byte")

endmodule

@@ hdl/wsfd_skid.sv @@
// output register with a skid entry between parser and result stream
// depends on wsfd_pkg and assert_macros.svh
`include "assert_macros.svh"

module wsfd_skid
  import wsfd_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    in_valid,
  output logic    in_ready,
  input  result_t in_data,
  output logic    out_valid,
  input  logic    out_ready,
  output result_t out_data
);

  logic    skid_valid;
  result_t skid_data;

  assign in_ready = ~skid_valid;

  // main register refills from the skid entry first, then from the input
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_ready || !out_valid) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= in_valid;
      end
    end else if (in_valid && in_ready) begin
      skid_valid <= 1'b1;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (out_ready || !out_valid) begin
      out_data <= skid_valid ? skid_data : in_data;
    end
    if (!(out_ready || !out_valid) && in_valid && in_ready) begin
      skid_data <= in_data;
    end
  end

  // checks
  `ASSERT_AT(a_skid_behind_out, clk, rst, !skid_valid || out_valid,
    "skid entry held with empty output register")
  `ASSERT_NEXT(a_skid_drains, clk, rst, skid_valid && out_ready, !skid_valid && out_valid,
    "skid entry not moved on request")

endmodule
